>>> design/llhp_pkg.sv
// shared types and constants for the log line header parser
// no dependencies; imported by every module of the block
package llhp_pkg;

   // fixed widths of the front-to-back job fields, sized for the largest
   // supported tag and digit buffer
   localparam int JOB_IDX_W = 5;
   localparam int JOB_CNT_W = 6;

   // result kinds
   localparam logic [1:0] KIND_TAG = 2'd0;
   localparam logic [1:0] KIND_MSG = 2'd1;
   localparam logic [1:0] KIND_REC = 2'd2;

   // level codes
   localparam logic [2:0] LVL_ERROR   = 3'd0;
   localparam logic [2:0] LVL_WARN    = 3'd1;
   localparam logic [2:0] LVL_INFO    = 3'd2;
   localparam logic [2:0] LVL_DEBUG   = 3'd3;
   localparam logic [2:0] LVL_VERBOSE = 3'd4;

   // characters
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_W     = 8'h57;
   localparam logic [7:0] CHAR_I     = 8'h49;
   localparam logic [7:0] CHAR_D     = 8'h44;
   localparam logic [7:0] CHAR_V     = 8'h56;

   // header parse phase, in header order
   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_SPACE  = 3'd1,
      PH_OPEN   = 3'd2,
      PH_DIGITS = 3'd3,
      PH_CLOSE  = 3'd4,
      PH_TAG    = 3'd5,
      PH_COLON  = 3'd6,
      PH_MSG    = 3'd7
   } phase_type;

   // write caused directly by the current byte
   typedef enum logic [1:0] {
      CUR_NONE = 2'd0,
      CUR_TAG  = 2'd1,
      CUR_MSG  = 2'd2
   } cur_type;

   // work for one item, handed from the classifier to the emitter
   typedef struct packed {
      logic                 dig_wr;
      logic [JOB_IDX_W-1:0] dig_idx;
      logic [3:0]           dig_val;
      logic                 msg_clear;
      logic                 rp_space;
      logic                 rp_open;
      logic [JOB_CNT_W-1:0] rp_ndig;
      logic                 rp_close;
      cur_type              cur;
      logic [JOB_CNT_W-1:0] tag_pos;
      logic [7:0]           cur_byte;
      logic                 rec;
      logic [2:0]           level;
      logic [31:0]          time_val;
      logic [JOB_CNT_W-1:0] tag_len;
      logic                 ovf;
   } job_type;

endpackage

>>> design/llhp_front.sv
// classifier: tracks the header shape byte by byte and builds at most one job per item
// depends on llhp_pkg
module llhp_front #(
   parameter int TAG_BYTES    = 16,
   parameter int DIGIT_BUFFER = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [7:0]       in_byte,
   input  logic             in_last,
   input  logic             queue_ready,
   output logic             push,
   output llhp_pkg::job_type push_job
);
   import llhp_pkg::*;

   localparam int TCW = $clog2(TAG_BYTES);
   localparam int DCW = $clog2(DIGIT_BUFFER + 1);

   phase_type        phase_ff, phase_in;
   logic [2:0]       level_ff, level_in;
   logic [31:0]      time_ff, time_in;
   logic [TCW-1:0]   tag_cnt_ff, tag_cnt_in;
   logic [DCW-1:0]   dig_cnt_ff, dig_cnt_in;
   logic             ended_ff, ended_in;
   logic             ovf_ff, ovf_in;

   logic             accept;
   logic             is_level;
   logic [2:0]       level_code;
   logic             is_digit;
   job_type          job;

   assign accept = in_valid && queue_ready;
   assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);

   always_comb begin
      unique case (in_byte)
         CHAR_E: begin is_level = 1'b1; level_code = LVL_ERROR;   end
         CHAR_W: begin is_level = 1'b1; level_code = LVL_WARN;    end
         CHAR_I: begin is_level = 1'b1; level_code = LVL_INFO;    end
         CHAR_D: begin is_level = 1'b1; level_code = LVL_DEBUG;   end
         CHAR_V: begin is_level = 1'b1; level_code = LVL_VERBOSE; end
         default: begin is_level = 1'b0; level_code = LVL_INFO;   end
      endcase
   end

   always_comb begin
      logic      do_fb;
      logic      msg_byte;
      phase_type fb_ph;
      logic      end_fb;

      phase_in   = phase_ff;
      level_in   = level_ff;
      time_in    = time_ff;
      tag_cnt_in = tag_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      ended_in   = ended_ff;
      ovf_in     = ovf_ff;
      job        = '0;
      do_fb      = 1'b0;
      msg_byte   = 1'b0;
      fb_ph      = phase_ff;
      end_fb     = 1'b0;

      if (!ended_ff) begin
         unique case (phase_ff)
            PH_START: begin
               if (in_byte == CHAR_NUL) begin
                  ended_in = 1'b1;
               end else begin
                  job.cur      = CUR_MSG;
                  job.cur_byte = in_byte;
                  if (is_level) begin
                     level_in = level_code;
                     phase_in = PH_SPACE;
                  end else begin
                     phase_in = PH_MSG;
                  end
               end
            end
            PH_SPACE: begin
               if (in_byte == CHAR_SPACE) phase_in = PH_OPEN;
               else begin do_fb = 1'b1; msg_byte = 1'b1; end
            end
            PH_OPEN: begin
               if (in_byte == CHAR_OPEN) phase_in = PH_DIGITS;
               else begin do_fb = 1'b1; msg_byte = 1'b1; end
            end
            PH_DIGITS: begin
               if (is_digit) begin
                  time_in = (time_ff << 3) + (time_ff << 1) + {28'd0, in_byte[3:0]};
                  if (dig_cnt_ff < DCW'(DIGIT_BUFFER)) begin
                     job.dig_wr  = 1'b1;
                     job.dig_idx = JOB_IDX_W'(dig_cnt_ff);
                     job.dig_val = in_byte[3:0];
                     dig_cnt_in  = DCW'(dig_cnt_ff + DCW'(1));
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else if (in_byte == CHAR_CLOSE) begin
                  phase_in = PH_CLOSE;
               end else begin
                  do_fb = 1'b1; msg_byte = 1'b1;
               end
            end
            PH_CLOSE: begin
               if (in_byte == CHAR_SPACE) begin
                  phase_in      = PH_TAG;
                  job.msg_clear = 1'b1;
               end else begin
                  do_fb = 1'b1; msg_byte = 1'b1;
               end
            end
            PH_TAG: begin
               if (in_byte == CHAR_NUL) begin
                  ended_in = 1'b1;
               end else if (in_byte == CHAR_COLON) begin
                  phase_in = PH_COLON;
               end else if (tag_cnt_ff < TCW'(TAG_BYTES - 1)) begin
                  job.cur      = CUR_TAG;
                  job.tag_pos  = JOB_CNT_W'(tag_cnt_ff);
                  job.cur_byte = in_byte;
                  tag_cnt_in   = TCW'(tag_cnt_ff + TCW'(1));
               end else begin
                  // tag full: this byte opens the message
                  phase_in     = PH_MSG;
                  job.cur      = CUR_MSG;
                  job.cur_byte = in_byte;
               end
            end
            PH_COLON: begin
               phase_in = PH_MSG;
               if (in_byte != CHAR_SPACE) msg_byte = 1'b1;
            end
            PH_MSG: begin
               msg_byte = 1'b1;
            end
         endcase

         if (msg_byte) begin
            if (in_byte == CHAR_NUL) begin
               ended_in = 1'b1;
            end else begin
               job.cur      = CUR_MSG;
               job.cur_byte = in_byte;
            end
         end
      end

      // header cut short by the line end
      if (in_last && !ended_in &&
          (phase_in == PH_SPACE || phase_in == PH_OPEN ||
           phase_in == PH_DIGITS || phase_in == PH_CLOSE)) begin
         end_fb = 1'b1;
         fb_ph  = phase_in;
      end

      if (do_fb || end_fb) begin
         job.rp_space = (fb_ph == PH_OPEN) || (fb_ph == PH_DIGITS) || (fb_ph == PH_CLOSE);
         job.rp_open  = (fb_ph == PH_DIGITS) || (fb_ph == PH_CLOSE);
         job.rp_ndig  = job.rp_open ? JOB_CNT_W'(dig_cnt_in) : '0;
         job.rp_close = (fb_ph == PH_CLOSE);
         level_in     = LVL_INFO;
         time_in      = '0;
         tag_cnt_in   = '0;
         phase_in     = PH_MSG;
      end

      if (in_last) begin
         job.rec      = 1'b1;
         job.level    = level_in;
         job.time_val = time_in;
         job.tag_len  = JOB_CNT_W'(tag_cnt_in);
         job.ovf      = ovf_in;
         phase_in     = PH_START;
         level_in     = LVL_INFO;
         time_in      = '0;
         tag_cnt_in   = '0;
         dig_cnt_in   = '0;
         ended_in     = 1'b0;
         ovf_in       = 1'b0;
      end
   end

   assign push_job = job;
   assign push = accept && (job.dig_wr || job.msg_clear || job.rp_space ||
                            job.rp_close || (job.cur != CUR_NONE) || job.rec);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         level_ff   <= LVL_INFO;
         time_ff    <= '0;
         tag_cnt_ff <= '0;
         dig_cnt_ff <= '0;
         ended_ff   <= 1'b0;
         ovf_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         level_ff   <= level_in;
         time_ff    <= time_in;
         tag_cnt_ff <= tag_cnt_in;
         dig_cnt_ff <= dig_cnt_in;
         ended_ff   <= ended_in;
         ovf_ff     <= ovf_in;
      end
   end

endmodule

>>> design/llhp_queue.sv
// two-entry job queue between the classifier and the emitter
// depends on llhp_pkg
module llhp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  llhp_pkg::job_type push_job,
   output logic             push_ready,
   input  logic             pop,
   output logic             head_valid,
   output llhp_pkg::job_type head_job
);
   import llhp_pkg::*;

   logic [1:0] count_ff, count_in;
   job_type    slot0_ff, slot0_in;
   job_type    slot1_ff, slot1_in;

   assign push_ready = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_job   = slot0_ff;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) slot0_in = push_job;
            else slot1_in = push_job;
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            slot0_in = slot1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               slot0_in = push_job;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = push_job;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

>>> design/llhp_back.sv
// emitter: expands each job into tag writes, message writes and line records
// depends on llhp_pkg; holds the digit store and the message counters
module llhp_back #(
   parameter int MSG_BYTES    = 128,
   parameter int DIGIT_BUFFER = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  llhp_pkg::job_type head_job,
   output logic             pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [1:0]       out_kind,
   output logic [6:0]       out_position,
   output logic [7:0]       out_byte,
   output logic [2:0]       out_level,
   output logic [31:0]      out_timestamp,
   output logic [3:0]       out_tag_length,
   output logic [6:0]       out_message_length,
   output logic             out_digit_overflow,
   output logic             out_run_last
);
   import llhp_pkg::*;

   localparam int MCW = $clog2(MSG_BYTES);
   localparam int DCW = $clog2(DIGIT_BUFFER + 1);
   localparam int DIW = $clog2(DIGIT_BUFFER);
   localparam logic [MCW-1:0] MSG_MAX = MCW'(MSG_BYTES - 1);

   logic [3:0]     digits_ff [DIGIT_BUFFER];

   logic [MCW-1:0] mcount_ff, mcount_in;
   logic [MCW-1:0] kept_ff, kept_in;
   logic           sp_done_ff, sp_done_in;
   logic           op_done_ff, op_done_in;
   logic [DCW-1:0] dig_idx_ff, dig_idx_in;
   logic           cl_done_ff, cl_done_in;
   logic           cur_done_ff, cur_done_in;

   logic           valid_ff, valid_in;
   logic [1:0]     kind_ff, kind_in;
   logic [6:0]     pos_ff, pos_in;
   logic [7:0]     byte_ff, byte_in;
   logic [2:0]     level_ff, level_in;
   logic [31:0]    ts_ff, ts_in;
   logic [3:0]     tlen_ff, tlen_in;
   logic [6:0]     mlen_ff, mlen_in;
   logic           ovf_ff, ovf_in;
   logic           last_ff, last_in;

   logic [DCW-1:0] ndig;
   logic           pend_sp, pend_op, pend_dg, pend_cl, pend_cur, pend_rec;
   logic           sel_sp, sel_op, sel_dg, sel_cl, sel_cur, sel_rec;
   logic           step;
   logic [MCW+6:0] mcount_ext, kept_ext;

   assign ndig       = DCW'(head_job.rp_ndig);
   assign pend_sp    = head_job.rp_space && !sp_done_ff;
   assign pend_op    = head_job.rp_open && !op_done_ff;
   assign pend_dg    = head_job.rp_open && (dig_idx_ff < ndig);
   assign pend_cl    = head_job.rp_close && !cl_done_ff;
   assign pend_cur   = (head_job.cur != CUR_NONE) && !cur_done_ff;
   assign pend_rec   = head_job.rec;

   // one step at a time, in replay order
   assign sel_sp  = pend_sp;
   assign sel_op  = !pend_sp && pend_op;
   assign sel_dg  = !pend_sp && !pend_op && pend_dg;
   assign sel_cl  = !pend_sp && !pend_op && !pend_dg && pend_cl;
   assign sel_cur = !pend_sp && !pend_op && !pend_dg && !pend_cl && pend_cur;
   assign sel_rec = !pend_sp && !pend_op && !pend_dg && !pend_cl && !pend_cur && pend_rec;

   assign step       = head_valid && (!valid_ff || out_ready);
   assign mcount_ext = (MCW + 7)'(mcount_ff);
   assign kept_ext   = (MCW + 7)'(kept_ff);

   always_comb begin
      logic           is_msg;
      logic           is_tag;
      logic [7:0]     wbyte;
      logic           wr_ok;
      logic [MCW-1:0] mcount_next;
      logic           sp_after, op_after, dg_after, cl_after, cur_after, rec_after;
      logic           msg_after, more_out;

      mcount_in   = mcount_ff;
      kept_in     = kept_ff;
      sp_done_in  = sp_done_ff;
      op_done_in  = op_done_ff;
      dig_idx_in  = dig_idx_ff;
      cl_done_in  = cl_done_ff;
      cur_done_in = cur_done_ff;
      valid_in    = valid_ff && !out_ready;
      kind_in     = kind_ff;
      pos_in      = pos_ff;
      byte_in     = byte_ff;
      level_in    = level_ff;
      ts_in       = ts_ff;
      tlen_in     = tlen_ff;
      mlen_in     = mlen_ff;
      ovf_in      = ovf_ff;
      last_in     = last_ff;
      pop         = 1'b0;

      is_tag = sel_cur && (head_job.cur == CUR_TAG);
      is_msg = sel_sp || sel_op || sel_dg || sel_cl || (sel_cur && head_job.cur == CUR_MSG);
      if (sel_sp) wbyte = CHAR_SPACE;
      else if (sel_op) wbyte = CHAR_OPEN;
      else if (sel_dg) wbyte = CHAR_ZERO + {4'd0, digits_ff[dig_idx_ff[DIW-1:0]]};
      else if (sel_cl) wbyte = CHAR_CLOSE;
      else wbyte = head_job.cur_byte;

      // message writes past the size limit are dropped
      wr_ok       = is_msg && (mcount_ff < MSG_MAX);
      mcount_next = wr_ok ? MCW'(mcount_ff + MCW'(1)) : mcount_ff;

      sp_after  = pend_sp && !sel_sp;
      op_after  = pend_op && !sel_op;
      dg_after  = pend_dg && !(sel_dg && (DCW'(dig_idx_ff + DCW'(1)) == ndig));
      cl_after  = pend_cl && !sel_cl;
      cur_after = pend_cur && !sel_cur;
      rec_after = pend_rec && !sel_rec;
      msg_after = sp_after || op_after || dg_after || cl_after ||
                  (cur_after && head_job.cur == CUR_MSG);
      more_out  = rec_after || (cur_after && head_job.cur == CUR_TAG) ||
                  (msg_after && (mcount_next < MSG_MAX));

      if (step) begin
         if (sel_sp) sp_done_in = 1'b1;
         if (sel_op) op_done_in = 1'b1;
         if (sel_dg) dig_idx_in = DCW'(dig_idx_ff + DCW'(1));
         if (sel_cl) cl_done_in = 1'b1;
         if (sel_cur) cur_done_in = 1'b1;

         if (wr_ok) begin
            valid_in  = 1'b1;
            kind_in   = KIND_MSG;
            pos_in    = mcount_ext[6:0];
            byte_in   = wbyte;
            mcount_in = mcount_next;
            if (wbyte != CHAR_LF && wbyte != CHAR_CR) kept_in = mcount_next;
         end else if (is_tag) begin
            valid_in = 1'b1;
            kind_in  = KIND_TAG;
            pos_in   = 7'(head_job.tag_pos);
            byte_in  = wbyte;
         end else if (sel_rec) begin
            valid_in = 1'b1;
            kind_in  = KIND_REC;
         end
         level_in = sel_rec ? head_job.level : 3'd0;
         ts_in    = sel_rec ? head_job.time_val : 32'd0;
         tlen_in  = sel_rec ? head_job.tag_len[3:0] : 4'd0;
         // a line that ends on the space after ')' has an empty message
         mlen_in  = (sel_rec && !head_job.msg_clear) ? kept_ext[6:0] : 7'd0;
         ovf_in   = sel_rec && head_job.ovf;
         if (sel_rec) begin
            pos_in  = 7'd0;
            byte_in = 8'd0;
         end
         last_in  = !more_out;

         if (!(sp_after || op_after || dg_after || cl_after || cur_after || rec_after)) begin
            pop         = 1'b1;
            sp_done_in  = 1'b0;
            op_done_in  = 1'b0;
            dig_idx_in  = '0;
            cl_done_in  = 1'b0;
            cur_done_in = 1'b0;
            if (head_job.msg_clear || sel_rec) begin
               mcount_in = '0;
               kept_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head_valid && head_job.dig_wr) begin
         digits_ff[head_job.dig_idx[DIW-1:0]] <= head_job.dig_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mcount_ff   <= '0;
         kept_ff     <= '0;
         sp_done_ff  <= 1'b0;
         op_done_ff  <= 1'b0;
         dig_idx_ff  <= '0;
         cl_done_ff  <= 1'b0;
         cur_done_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         mcount_ff   <= mcount_in;
         kept_ff     <= kept_in;
         sp_done_ff  <= sp_done_in;
         op_done_ff  <= op_done_in;
         dig_idx_ff  <= dig_idx_in;
         cl_done_ff  <= cl_done_in;
         cur_done_ff <= cur_done_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      pos_ff   <= pos_in;
      byte_ff  <= byte_in;
      level_ff <= level_in;
      ts_ff    <= ts_in;
      tlen_ff  <= tlen_in;
      mlen_ff  <= mlen_in;
      ovf_ff   <= ovf_in;
      last_ff  <= last_in;
   end

   assign out_valid          = valid_ff;
   assign out_kind           = kind_ff;
   assign out_position       = pos_ff;
   assign out_byte           = byte_ff;
   assign out_level          = level_ff;
   assign out_timestamp      = ts_ff;
   assign out_tag_length     = tlen_ff;
   assign out_message_length = mlen_ff;
   assign out_digit_overflow = ovf_ff;
   assign out_run_last       = last_ff;

endmodule

>>> design/log_line_header_parser_unit.sv
// an item's job is registered in the queue; its first result then in the output register
// throughput: the classifier takes one byte per cycle while its two-entry queue has room;
// the emitter gives one result per cycle while jobs wait and the receiver is ready, so
// a broken header replays its held bytes one per cycle as message writes
// reset: synchronous, active high; clears line state, queue and output register
// top level of the log line header parser; depends on llhp_pkg, llhp_front,
// llhp_queue and llhp_back
module log_line_header_parser_unit #(
   parameter int TAG_BYTES    = 16,
   parameter int MSG_BYTES    = 128,
   parameter int DIGIT_BUFFER = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input item channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   input  logic        req_line_end,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [6:0]  rsp_position,
   output logic [7:0]  rsp_byte_out,
   output logic [2:0]  rsp_level,
   output logic [31:0] rsp_timestamp,
   output logic [3:0]  rsp_tag_length,
   output logic [6:0]  rsp_message_length,
   output logic        rsp_digit_overflow,
   output logic        rsp_run_last
);
   import llhp_pkg::*;

   // front side: classifier output into the queue
   logic    push;
   logic    push_ready;
   job_type push_job;

   // back side: queue head into the emitter
   logic    head_valid;
   logic    pop;
   job_type head_job;

   // an item is taken whenever the queue can hold its job
   assign req_ready = push_ready;

   // header parse state, level, time, tag count and digit count live here
   llhp_front #(
      .TAG_BYTES    (TAG_BYTES),
      .DIGIT_BUFFER (DIGIT_BUFFER)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_byte     (req_byte_in),
      .in_last     (req_line_end),
      .queue_ready (push_ready),
      .push        (push),
      .push_job    (push_job)
   );

   // decouples the classifier from output stalls and replay bursts
   llhp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // digit store, message counters and the registered result port
   llhp_back #(
      .MSG_BYTES    (MSG_BYTES),
      .DIGIT_BUFFER (DIGIT_BUFFER)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_job           (head_job),
      .pop                (pop),
      .out_valid          (rsp_valid),
      .out_ready          (rsp_ready),
      .out_kind           (rsp_kind),
      .out_position       (rsp_position),
      .out_byte           (rsp_byte_out),
      .out_level          (rsp_level),
      .out_timestamp      (rsp_timestamp),
      .out_tag_length     (rsp_tag_length),
      .out_message_length (rsp_message_length),
      .out_digit_overflow (rsp_digit_overflow),
      .out_run_last       (rsp_run_last)
   );

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for log_line_header_parser_unit
// depends on llhp_pkg and the design files; predicts every tag, message and record item

module tb;
   import llhp_pkg::*;

   localparam int TAG_BYTES    = 16;
   localparam int MSG_BYTES    = 128;
   localparam int DIGIT_BUFFER = 16;

   // last stretch of stimulus runs with both sides at full rate
   localparam int TAIL_ITEMS   = 40;
   // long receiver hold-off so the input queue fills and req_ready drops
   localparam int HOLD_AFTER   = 80;
   localparam int HOLD_CYCLES  = 150;
   localparam int SETTLE_CYCLES = 30;
   localparam int MAX_REPORTS  = 40;

   // one byte of a log line as offered on the input channel
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } line_item_type;

   // one item on the result channel
   typedef struct packed {
      logic [1:0]  kind;
      logic [6:0]  position;
      logic [7:0]  byte_out;
      logic [2:0]  level;
      logic [31:0] timestamp;
      logic [3:0]  tag_length;
      logic [6:0]  message_length;
      logic        digit_overflow;
      logic        run_last;
   } parse_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_byte_in = 8'h00;
   logic        req_line_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [6:0]  rsp_position;
   logic [7:0]  rsp_byte_out;
   logic [2:0]  rsp_level;
   logic [31:0] rsp_timestamp;
   logic [3:0]  rsp_tag_length;
   logic [6:0]  rsp_message_length;
   logic        rsp_digit_overflow;
   logic        rsp_run_last;

   log_line_header_parser_unit #(
      .TAG_BYTES    (TAG_BYTES),
      .MSG_BYTES    (MSG_BYTES),
      .DIGIT_BUFFER (DIGIT_BUFFER)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_byte_in        (req_byte_in),
      .req_line_end       (req_line_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_position       (rsp_position),
      .rsp_byte_out       (rsp_byte_out),
      .rsp_level          (rsp_level),
      .rsp_timestamp      (rsp_timestamp),
      .rsp_tag_length     (rsp_tag_length),
      .rsp_message_length (rsp_message_length),
      .rsp_digit_overflow (rsp_digit_overflow),
      .rsp_run_last       (rsp_run_last)
   );

   // stimulus and expectation stores
   line_item_type    line_bytes[$];
   logic [7:0]       line_buf[$];
   parse_result_type parsed_results[$];

   logic [7:0] level_chars [5] = '{CHAR_E, CHAR_W, CHAR_I, CHAR_D, CHAR_V};

   // handshake bookkeeping shared between processes
   bit req_accepted = 1'b0;
   bit idle_ok = 1'b1;
   int items_taken = 0;
   int fail_count = 0;
   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   // header parser state of the predictor
   phase_type   hdr_phase;
   logic [2:0]  lvl_seen;
   logic [31:0] time_acc;
   logic [3:0]  digit_store [DIGIT_BUFFER];
   int          digit_count;
   int          tag_count;
   int          msg_count;
   int          kept_len;
   bit          content_done;
   bit          digits_over;
   int          step_results;

   initial begin
      forever #6 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   task automatic clear_line();
      hdr_phase    = PH_START;
      lvl_seen     = LVL_INFO;
      time_acc     = 32'd0;
      digit_count  = 0;
      tag_count    = 0;
      msg_count    = 0;
      kept_len     = 0;
      content_done = 1'b0;
      digits_over  = 1'b0;
   endtask

   task automatic put_result(input logic [1:0] kind, input logic [6:0] pos,
                             input logic [7:0] data, input logic [2:0] lvl,
                             input logic [31:0] stamp, input logic [3:0] tlen,
                             input logic [6:0] mlen, input logic ovf);
      parse_result_type r;
      r.kind           = kind;
      r.position       = pos;
      r.byte_out       = data;
      r.level          = lvl;
      r.timestamp      = stamp;
      r.tag_length     = tlen;
      r.message_length = mlen;
      r.digit_overflow = ovf;
      r.run_last       = 1'b0;
      parsed_results.push_back(r);
      step_results++;
   endtask

   // message write, dropped once the message is full;
   // trailing cr and lf do not count toward the kept length
   task automatic put_msg(input logic [7:0] b);
      if (msg_count >= MSG_BYTES - 1) return;
      put_result(KIND_MSG, 7'(msg_count), b, 3'd0, 32'd0, 4'd0, 7'd0, 1'b0);
      msg_count++;
      if (b != CHAR_LF && b != CHAR_CR) kept_len = msg_count;
   endtask

   // a zero byte ends the content, anything else goes to the message
   task automatic msg_or_end(input logic [7:0] b);
      if (b == CHAR_NUL) content_done = 1'b1;
      else put_msg(b);
   endtask

   // broken header: replay the held-back bytes and fall back to defaults
   task automatic replay_header();
      if (hdr_phase >= PH_OPEN) put_msg(CHAR_SPACE);
      if (hdr_phase >= PH_DIGITS) begin
         put_msg(CHAR_OPEN);
         for (int i = 0; i < digit_count; i++)
            put_msg(CHAR_ZERO + {4'd0, digit_store[i]});
      end
      if (hdr_phase == PH_CLOSE) put_msg(CHAR_CLOSE);
      lvl_seen  = LVL_INFO;
      time_acc  = 32'd0;
      tag_count = 0;
      hdr_phase = PH_MSG;
   endtask

   // expected items for one accepted input item
   task automatic parse_byte(input logic [7:0] b, input logic last);
      parse_result_type tail;
      step_results = 0;
      if (!content_done) begin
         case (hdr_phase)
            PH_START: begin
               if (b == CHAR_NUL) content_done = 1'b1;
               else begin
                  // first byte is written right away as message byte 0
                  put_msg(b);
                  hdr_phase = PH_SPACE;
                  case (b)
                     CHAR_E: lvl_seen = LVL_ERROR;
                     CHAR_W: lvl_seen = LVL_WARN;
                     CHAR_I: lvl_seen = LVL_INFO;
                     CHAR_D: lvl_seen = LVL_DEBUG;
                     CHAR_V: lvl_seen = LVL_VERBOSE;
                     default: hdr_phase = PH_MSG;
                  endcase
               end
            end
            PH_SPACE: begin
               if (b == CHAR_SPACE) hdr_phase = PH_OPEN;
               else begin
                  replay_header();
                  msg_or_end(b);
               end
            end
            PH_OPEN: begin
               if (b == CHAR_OPEN) hdr_phase = PH_DIGITS;
               else begin
                  replay_header();
                  msg_or_end(b);
               end
            end
            PH_DIGITS: begin
               if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                  // every digit enters the time, only the first DIGIT_BUFFER are stored
                  time_acc = time_acc * 32'd10 + {24'd0, b - CHAR_ZERO};
                  if (digit_count < DIGIT_BUFFER) begin
                     digit_store[digit_count] = 4'(b - CHAR_ZERO);
                     digit_count++;
                  end else begin
                     digits_over = 1'b1;
                  end
               end else if (b == CHAR_CLOSE) begin
                  hdr_phase = PH_CLOSE;
               end else begin
                  replay_header();
                  msg_or_end(b);
               end
            end
            PH_CLOSE: begin
               if (b == CHAR_SPACE) begin
                  // header parsed: message restarts at position 0
                  hdr_phase = PH_TAG;
                  msg_count = 0;
                  kept_len  = 0;
               end else begin
                  replay_header();
                  msg_or_end(b);
               end
            end
            PH_TAG: begin
               if (b == CHAR_NUL) content_done = 1'b1;
               else if (b == CHAR_COLON) hdr_phase = PH_COLON;
               else if (tag_count < TAG_BYTES - 1) begin
                  put_result(KIND_TAG, 7'(tag_count), b, 3'd0, 32'd0, 4'd0, 7'd0, 1'b0);
                  tag_count++;
               end else begin
                  // tag full and no colon: message starts here
                  hdr_phase = PH_MSG;
                  put_msg(b);
               end
            end
            PH_COLON: begin
               hdr_phase = PH_MSG;
               if (b != CHAR_SPACE) msg_or_end(b);
            end
            default: msg_or_end(b);
         endcase
      end
      if (last) begin
         if (!content_done && hdr_phase >= PH_SPACE && hdr_phase <= PH_CLOSE)
            replay_header();
         put_result(KIND_REC, 7'd0, 8'd0, lvl_seen, time_acc, 4'(tag_count),
                    7'(kept_len), digits_over);
         clear_line();
      end
      if (step_results > 0) begin
         tail = parsed_results.pop_back();
         tail.run_last = 1'b1;
         parsed_results.push_back(tail);
      end
   endtask

   // ------------------------------------------------------------------
   // stimulus building
   // ------------------------------------------------------------------

   // move the line under construction to the send queue, line_end on its last byte
   task automatic flush_line();
      line_item_type it;
      for (int i = 0; i < line_buf.size(); i++) begin
         it.data = line_buf[i];
         it.last = (i == line_buf.size() - 1);
         line_bytes.push_back(it);
      end
      line_buf.delete();
   endtask

   task automatic add_text(input string s);
      line_buf.delete();
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
      flush_line();
   endtask

   // one random line: mostly well-formed headers with random content,
   // some cut short or corrupted, some plain noise
   task automatic gen_line(input bit long_msg);
      int n;
      int cut;
      int shape;
      logic [7:0] b;
      line_buf.delete();
      shape = $urandom_range(0, 99);
      if (shape < 12 && !long_msg) begin
         n = $urandom_range(1, 6);
         repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
         line_buf.push_back(level_chars[$urandom_range(0, 4)]);
         line_buf.push_back(CHAR_SPACE);
         line_buf.push_back(CHAR_OPEN);
         // digit run: empty, at or past the digit buffer size, or ordinary
         case ($urandom_range(0, 9))
            0: n = 0;
            1: n = $urandom_range(DIGIT_BUFFER, DIGIT_BUFFER + 6);
            default: n = $urandom_range(1, 10);
         endcase
         repeat (n) line_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
         line_buf.push_back(CHAR_CLOSE);
         line_buf.push_back(CHAR_SPACE);
         // tag: empty, around the full size, or short
         case ($urandom_range(0, 7))
            0: n = 0;
            1: n = $urandom_range(TAG_BYTES - 2, TAG_BYTES + 2);
            default: n = $urandom_range(1, 6);
         endcase
         repeat (n) begin
            do b = 8'($urandom_range(1, 255)); while (b == CHAR_COLON);
            line_buf.push_back(b);
         end
         line_buf.push_back(CHAR_COLON);
         if ($urandom_range(0, 3) != 0) line_buf.push_back(CHAR_SPACE);
         n = long_msg ? MSG_BYTES + 12 : $urandom_range(0, 12);
         repeat (n) line_buf.push_back(8'($urandom_range(1, 255)));
         case ($urandom_range(0, 5))
            0: begin
               line_buf.push_back(CHAR_CR);
               line_buf.push_back(CHAR_LF);
            end
            1: line_buf.push_back(CHAR_LF);
            2: line_buf.push_back(CHAR_CR);
            3: begin
               // content ends early, trailing bytes are ignored
               line_buf.push_back(CHAR_NUL);
               line_buf.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
         endcase
         // broken header or cut line
         if (shape < 35 && !long_msg) begin
            cut = $urandom_range(1, line_buf.size());
            while (line_buf.size() > cut) void'(line_buf.pop_back());
            if ($urandom_range(0, 1) == 1) begin
               void'(line_buf.pop_back());
               line_buf.push_back(8'($urandom_range(0, 255)));
            end
         end
      end
      flush_line();
   endtask

   initial begin : stimulus
      int line_no;
      clear_line();

      // directed lines
      line_buf.push_back(CHAR_NUL);              // zero byte as first byte
      line_buf.push_back(CHAR_E);                // ignored after it
      flush_line();
      line_buf.push_back(8'hFF);                 // not a level letter
      flush_line();
      add_text("V");                             // line ends before the space
      add_text("D (");                           // line ends in front of the digits
      add_text("I (9)");                         // line ends after ')'
      add_text("W ( ");                          // non-digit inside the parentheses
      add_text("E (1) :x");                      // empty tag, no space after colon

      // the first random line carries a message past the size limit
      line_no = 0;
      while (line_bytes.size() < 200) begin
         gen_line(line_no == 0);
         line_no++;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (line_bytes.size() != 0 || req_valid) @(posedge clock);
      while (parsed_results.size() != 0) @(posedge clock);
      // a line can end with results still on their way; give stragglers time
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // input driver: offers the next byte at the falling edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin : driver
      line_item_type nxt;
      if (!reset) begin
         if (!req_valid || req_accepted) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (line_bytes.size() > 0) begin
               nxt = line_bytes.pop_front();
               req_valid    <= 1'b1;
               req_byte_in  <= nxt.data;
               req_line_end <= nxt.last;
               if (idle_ok && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 8);
            end else begin
               req_valid <= 1'b0;
            end
         end
         req_accepted = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // result receiver: random stall bursts plus one long hold-off
   // ------------------------------------------------------------------
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && items_taken >= HOLD_AFTER) begin
         // block backs up while the sender keeps offering
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // monitor: predicts on accepted input items, checks accepted results
   // ------------------------------------------------------------------

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         if (fail_count < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      parse_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            parse_byte(req_byte_in, req_line_end);
            req_accepted = 1'b1;
            items_taken++;
         end
         // no quiet stretches in every third band, nor in the tail
         idle_ok = (line_bytes.size() > TAIL_ITEMS) && ((items_taken / 40) % 3 != 2);

         if (rsp_valid && rsp_ready) begin
            if (parsed_results.size() == 0) begin
               if (fail_count < MAX_REPORTS)
                  $display("%0t: unexpected item, expected none, actual kind %0d pos %0d",
                           $time, rsp_kind, rsp_position);
               fail_count++;
            end else begin
               want = parsed_results.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_kind));
               check_field("position", 32'(want.position), 32'(rsp_position));
               check_field("byte_out", 32'(want.byte_out), 32'(rsp_byte_out));
               check_field("level", 32'(want.level), 32'(rsp_level));
               check_field("timestamp", want.timestamp, rsp_timestamp);
               check_field("tag_length", 32'(want.tag_length), 32'(rsp_tag_length));
               check_field("message_length", 32'(want.message_length),
                           32'(rsp_message_length));
               check_field("digit_overflow", 32'(want.digit_overflow),
                           32'(rsp_digit_overflow));
               check_field("run_last", 32'(want.run_last), 32'(rsp_run_last));
            end
         end
      end
   end

endmodule

>>> files.f
design/llhp_pkg.sv
design/llhp_front.sv
design/llhp_queue.sv
design/llhp_back.sv
design/log_line_header_parser_unit.sv
verif/tb.sv
